@@ rtl/bitstream_sync_align_packer_macros.svh @@
// assertion macros for the bitstream sync aligner checker
`ifndef BITSTREAM_SYNC_ALIGN_PACKER_MACROS_SVH
`define BITSTREAM_SYNC_ALIGN_PACKER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define BSAP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsap check failed");

// antecedent implies consequent in the next cycle
`define BSAP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsap check failed");

`endif

@@ rtl/bsap_pkg.sv @@
// shared constants, types and functions of the bitstream sync aligner
`default_nettype none

package bsap_pkg;

  localparam logic [31:0] SYNC_NORMAL  = 32'h6655_99AA;
  localparam logic [31:0] SYNC_SWAPPED = 32'hAA99_5566;

  localparam logic CMD_DATA    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  typedef struct packed {
    logic        valid;
    logic [31:0] word;
    logic        swapped;
    logic        is_sync;
  } result_t;

  function automatic logic [31:0] reverse_bytes(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

`default_nettype wire

@@ rtl/bsap_core.sv @@
// sync word hunt state and word packing, one item per cycle while fire_i is high
`default_nettype none

module bsap_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  wire logic             command_i,
  input  wire logic [7:0]       data_byte_i,
  output bsap_pkg::result_t     result_o
);
  import bsap_pkg::*;

  logic        hunting_q, hunting_d;
  logic [23:0] history_q, history_d;
  logic        swap_q, swap_d;
  logic [1:0]  fill_q, fill_d;
  logic [23:0] partial_q, partial_d;

  logic [31:0] window;
  logic        match_n;
  logic        match_s;
  logic [31:0] packed_word;

  assign window      = {history_q, data_byte_i};
  assign match_n     = (window == SYNC_NORMAL);
  assign match_s     = (window == SYNC_SWAPPED);
  assign packed_word = {data_byte_i, partial_q};

  always_comb begin
    hunting_d = hunting_q;
    history_d = history_q;
    swap_d    = swap_q;
    fill_d    = fill_q;
    partial_d = partial_q;
    result_o  = '0;
    if (command_i == CMD_RESTART) begin
      hunting_d = 1'b1;
      history_d = '0;
      swap_d    = 1'b0;
      fill_d    = '0;
      partial_d = '0;
    end else if (hunting_q) begin
      if (match_n || match_s) begin
        hunting_d        = 1'b0;
        history_d        = '0;
        swap_d           = match_s;
        fill_d           = '0;
        partial_d        = '0;
        result_o.valid   = 1'b1;
        result_o.word    = match_s ? reverse_bytes(reverse_bytes(window))
                                   : reverse_bytes(window);
        result_o.swapped = match_s;
        result_o.is_sync = 1'b1;
      end else begin
        history_d = window[23:0];
      end
    end else begin
      case (fill_q)
        2'd0: begin
          partial_d = {partial_q[23:8], data_byte_i};
          fill_d    = 2'd1;
        end
        2'd1: begin
          partial_d = {partial_q[23:16], data_byte_i, partial_q[7:0]};
          fill_d    = 2'd2;
        end
        2'd2: begin
          partial_d = {data_byte_i, partial_q[15:0]};
          fill_d    = 2'd3;
        end
        2'd3: begin
          partial_d        = '0;
          fill_d           = 2'd0;
          result_o.valid   = 1'b1;
          result_o.word    = swap_q ? reverse_bytes(packed_word) : packed_word;
          result_o.swapped = swap_q;
          result_o.is_sync = 1'b0;
        end
        default: begin
          fill_d = 2'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hunting_q <= 1'b1;
      history_q <= '0;
      swap_q    <= 1'b0;
      fill_q    <= '0;
      partial_q <= '0;
    end else if (fire_i) begin
      hunting_q <= hunting_d;
      history_q <= history_d;
      swap_q    <= swap_d;
      fill_q    <= fill_d;
      partial_q <= partial_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/bitstream_sync_align_packer.sv @@
// top level of the bitstream sync aligner and 32-bit word packer
`default_nettype none

// Takes one bitstream item (data byte or restart command) per clock while
// in_stall_o is low and emits a 32-bit word for every fourth byte after the
// sync word, the sync word itself first. Sustained rate is one item per cycle
// while the output does not stall; an item passes an input register and the
// hunt/pack logic into the output register, which drives the outputs. Input
// stall rises only when the output register holds a stalled word and the item
// waiting in the input register would complete another word.

module bitstream_sync_align_packer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic        command_i,
  input  wire logic [7:0]  data_byte_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [31:0] config_word_o,
  output      logic        swapped_order_o,
  output      logic        is_sync_word_o
);
  import bsap_pkg::*;

  logic        s1_valid_q;
  logic        s1_cmd_q;
  logic [7:0]  s1_byte_q;
  logic        out_valid_q;
  logic [31:0] out_word_q;
  logic        out_swapped_q;
  logic        out_sync_q;

  result_t     res;
  logic        out_free;
  logic        s1_fire;
  logic        in_take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && (!res.valid || out_free);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_take    = in_valid_i && !in_stall_o;

  bsap_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (s1_fire),
    .command_i   (s1_cmd_q),
    .data_byte_i (s1_byte_q),
    .result_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_cmd_q  <= command_i;
      s1_byte_q <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && res.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && res.valid) begin
      out_word_q    <= res.word;
      out_swapped_q <= res.swapped;
      out_sync_q    <= res.is_sync;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign config_word_o   = out_word_q;
  assign swapped_order_o = out_swapped_q;
  assign is_sync_word_o  = out_sync_q;

endmodule

`default_nettype wire

@@ rtl/bsap_checker.sv @@
// port-level checker for the bitstream sync aligner, bound to the top level
`default_nettype none
`include "bitstream_sync_align_packer_macros.svh"

module bsap_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] config_word_o,
  input wire logic        is_sync_word_o
);
  import bsap_pkg::*;

  // output item holds while stalled
  `BSAP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `BSAP_ASSERT_NEXT(a_out_stable, clk_i, rst_ni,
                    out_valid_o && out_stall_i, $stable(config_word_o))

  // input stalls only behind a stalled output item
  `BSAP_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // the sync word always reads in packed order
  `BSAP_ASSERT_NOW(a_sync_value, clk_i, rst_ni,
                   out_valid_o && is_sync_word_o, config_word_o == SYNC_SWAPPED)

endmodule

bind bitstream_sync_align_packer bsap_checker u_bsap_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .config_word_o  (config_word_o),
  .is_sync_word_o (is_sync_word_o)
);

`default_nettype wire
